@@ design/assert_macros.svh @@
// Shared assertion macros for the gradient histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is high.
`define GHFS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked check that also holds during reset.
`define GHFS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

@@ design/ghfs_pkg.sv @@
// ---------------------------------------------------------------------------
// ghfs_pkg
// Types, constants and codes shared by the gradient histogram block.
// ---------------------------------------------------------------------------
package ghfs_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;
   localparam int NUM_BINS    = 16;
   localparam int LINES       = 4;
   localparam int WIN         = 5;

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT + 3);
   localparam int BIN_W       = $clog2(NUM_BINS);

   localparam int PIX_W       = 8;
   localparam int IMG_W_W     = 11;
   localparam int ROI_W       = 10;
   localparam int THR_S_W     = 11;
   localparam int THR_L_W     = 14;
   localparam int CNT_W       = 20;
   localparam int MAG_W       = 13;
   localparam int RAD_W       = 27;
   localparam int ROOT_W      = 14;
   localparam int PEAK_S_W    = 11;
   localparam int PEAK_L_W    = 14;
   localparam int ITER_W      = 4;

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 14;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
   localparam logic [RAD_W-1:0] ROOT_START = RAD_W'(1) << (RAD_W - 1);

   // Row weights of the 5x5 kernels written as shift amounts (1, 2, 4, 2, 1).
   localparam logic [1:0] ROW_SHIFT [WIN] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd0};

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IMAGE_WIDTH   = 3'd0,
      REG_ROI_COL_START = 3'd1,
      REG_ROI_COL_END   = 3'd2,
      REG_ROI_ROW_START = 3'd3,
      REG_ROI_ROW_END   = 3'd4,
      REG_THR_SMALL     = 3'd5,
      REG_THR_LARGE     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [IMG_W_W-1:0] image_width;
      logic [ROI_W-1:0]   roi_col_start;
      logic [ROI_W-1:0]   roi_col_end;
      logic [ROI_W-1:0]   roi_row_start;
      logic [ROI_W-1:0]   roi_row_end;
      logic [THR_S_W-1:0] thr_small;
      logic [THR_L_W-1:0] thr_large;
   } cfg_type;

   // One unit of work for the back end: magnitudes and positive-tap sums.
   typedef struct packed {
      logic             evaluate;
      logic             eof;
      logic [MAG_W-1:0] mag_h3;
      logic [MAG_W-1:0] div_h3;
      logic [MAG_W-1:0] mag_v3;
      logic [MAG_W-1:0] div_v3;
      logic [MAG_W-1:0] mag_h5;
      logic [MAG_W-1:0] div_h5;
      logic [MAG_W-1:0] mag_v5;
      logic [MAG_W-1:0] div_v5;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } queue_wr_type;

   typedef struct packed {
      logic    empty;
      logic    full;
      job_type head;
   } queue_status_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_SHIFT,
      FE_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BE_IDLE,
      BE_DISPATCH,
      BE_DIV_LOAD,
      BE_DIV,
      BE_SQ_H,
      BE_SQ_V,
      BE_SQRT,
      BE_UPDATE,
      BE_EMIT_LOAD,
      BE_EMIT_WAIT
   } back_state_type;

endpackage

@@ design/ghfs_if.sv @@
// ---------------------------------------------------------------------------
// ghfs_if
// Channel interfaces: pixel input, bin record output and register writes.
// ---------------------------------------------------------------------------
interface ghfs_req_if;
   logic                        valid;
   logic                        ready;
   logic [ghfs_pkg::PIX_W-1:0]  pixel;
   logic                        end_of_frame;
   modport source (output valid, pixel, end_of_frame, input ready);
   modport sink   (input valid, pixel, end_of_frame, output ready);
endinterface

interface ghfs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ghfs_pkg::BIN_W-1:0]    bin_index;
   logic [ghfs_pkg::CNT_W-1:0]    count_small;
   logic [ghfs_pkg::CNT_W-1:0]    count_large;
   logic [ghfs_pkg::PEAK_S_W-1:0] max_small;
   logic [ghfs_pkg::PEAK_L_W-1:0] max_large;
   logic                          is_clear;
   logic                          last;
   modport source (output valid, bin_index, count_small, count_large, max_small,
                   max_large, is_clear, last, input ready);
   modport sink   (input valid, bin_index, count_small, count_large, max_small,
                   max_large, is_clear, last, output ready);
endinterface

interface ghfs_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ghfs_pkg::CSR_IDX_W-1:0]  reg_index;
   logic [ghfs_pkg::CSR_DATA_W-1:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ design/ghfs_front.sv @@
// ---------------------------------------------------------------------------
// ghfs_front
// Line buffers, 5x5 window, position counters and kernel tap sums.
// ---------------------------------------------------------------------------
module ghfs_front (
   input  logic                       clock,
   input  logic                       reset,
   ghfs_req_if.sink                   req,
   input  ghfs_pkg::cfg_type          cfg,
   input  ghfs_pkg::queue_status_type qstat,
   output ghfs_pkg::queue_wr_type     qwr
);
   import ghfs_pkg::*;

   front_state_type state_ff, state_in;

   logic [PIX_W-1:0] line_mem [LINES][MAX_WIDTH];
   logic [PIX_W-1:0] rd_ff [LINES];
   logic [PIX_W-1:0] win_ff [WIN][WIN];
   logic [PIX_W-1:0] colv [WIN];
   logic [PIX_W-1:0] px_ff;
   logic             eof_ff;
   logic             eval_ff;
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;

   logic [COL_W:0]   width_eff;
   logic             line_end;
   logic [ROW_W-1:0] cr;
   logic [COL_W-1:0] cc;
   logic             eval_in;
   logic             need_push;

   logic [MAG_W-1:0] hp3, hn3, vp3, vn3, hp5, hn5, vp5, vn5;

   assign req.ready = (state_ff == FE_IDLE);

   assign colv[0] = rd_ff[3];
   assign colv[1] = rd_ff[2];
   assign colv[2] = rd_ff[1];
   assign colv[3] = rd_ff[0];
   assign colv[4] = px_ff;

   always_comb begin
      if (cfg.image_width == '0) begin
         width_eff = (COL_W+1)'(1);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         width_eff = (COL_W+1)'(MAX_WIDTH);
      end else begin
         width_eff = (COL_W+1)'(cfg.image_width);
      end
   end

   assign line_end = ({1'b0, col_ff} + (COL_W+1)'(1)) >= width_eff;

   // The window centre sits two rows up and two columns left of the newest pixel.
   assign cr = row_ff - ROW_W'(2);
   assign cc = col_ff - COL_W'(2);
   assign eval_in = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2)) &&
                    (32'(cr) < MAX_HEIGHT) &&
                    (cr >= ROW_W'(cfg.roi_row_start)) && (cr < ROW_W'(cfg.roi_row_end)) &&
                    (cc >= COL_W'(cfg.roi_col_start)) && (cc < COL_W'(cfg.roi_col_end));

   always_ff @(posedge clock) begin
      for (int k = 0; k < LINES; k++) begin
         rd_ff[k] <= line_mem[k][col_ff];
      end
      if (state_ff == FE_SHIFT) begin
         line_mem[0][col_ff] <= px_ff;
         for (int k = 1; k < LINES; k++) begin
            line_mem[k][col_ff] <= rd_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         px_ff  <= req.pixel;
         eof_ff <= req.end_of_frame;
      end
      if (state_ff == FE_SHIFT) begin
         eval_ff <= eval_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         for (int r = 0; r < WIN; r++) begin
            for (int c = 0; c < WIN; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == FE_SHIFT) begin
            for (int r = 0; r < WIN; r++) begin
               for (int c = 0; c < WIN-1; c++) begin
                  win_ff[r][c] <= win_ff[r][c+1];
               end
               win_ff[r][WIN-1] <= colv[r];
            end
            if (eof_ff) begin
               col_ff <= '0;
               row_ff <= '0;
            end else if (line_end) begin
               col_ff <= '0;
               if (32'(row_ff) < MAX_HEIGHT + 2) begin
                  row_ff <= row_ff + ROW_W'(1);
               end
            end else begin
               col_ff <= col_ff + COL_W'(1);
            end
         end
      end
   end

   // Tap sums of the positive and negative halves of each kernel.
   always_comb begin
      hp3 = MAG_W'(win_ff[1][3]) + (MAG_W'(win_ff[2][3]) << 1) + MAG_W'(win_ff[3][3]);
      hn3 = MAG_W'(win_ff[1][1]) + (MAG_W'(win_ff[2][1]) << 1) + MAG_W'(win_ff[3][1]);
      vp3 = MAG_W'(win_ff[3][1]) + (MAG_W'(win_ff[3][2]) << 1) + MAG_W'(win_ff[3][3]);
      vn3 = MAG_W'(win_ff[1][1]) + (MAG_W'(win_ff[1][2]) << 1) + MAG_W'(win_ff[1][3]);
      hp5 = '0;
      hn5 = '0;
      vp5 = '0;
      vn5 = '0;
      for (int i = 0; i < WIN; i++) begin
         hp5 = hp5 + (((MAG_W'(win_ff[i][3]) << 1) + MAG_W'(win_ff[i][4])) << ROW_SHIFT[i]);
         hn5 = hn5 + (((MAG_W'(win_ff[i][1]) << 1) + MAG_W'(win_ff[i][0])) << ROW_SHIFT[i]);
         vp5 = vp5 + (((MAG_W'(win_ff[3][i]) << 1) + MAG_W'(win_ff[4][i])) << ROW_SHIFT[i]);
         vn5 = vn5 + (((MAG_W'(win_ff[1][i]) << 1) + MAG_W'(win_ff[0][i])) << ROW_SHIFT[i]);
      end
   end

   always_comb begin
      qwr.job.evaluate = eval_ff;
      qwr.job.eof      = eof_ff;
      qwr.job.mag_h3   = (hp3 >= hn3) ? hp3 - hn3 : hn3 - hp3;
      qwr.job.div_h3   = hp3;
      qwr.job.mag_v3   = (vp3 >= vn3) ? vp3 - vn3 : vn3 - vp3;
      qwr.job.div_v3   = vp3;
      qwr.job.mag_h5   = (hp5 >= hn5) ? hp5 - hn5 : hn5 - hp5;
      qwr.job.div_h5   = hp5;
      qwr.job.mag_v5   = (vp5 >= vn5) ? vp5 - vn5 : vn5 - vp5;
      qwr.job.div_v5   = vp5;
   end

   assign need_push = eval_ff || eof_ff;

   always_comb begin
      state_in = state_ff;
      qwr.push = 1'b0;
      unique case (state_ff)
         FE_IDLE: begin
            if (req.valid) begin
               state_in = FE_SHIFT;
            end
         end
         FE_SHIFT: begin
            state_in = FE_PUSH;
         end
         FE_PUSH: begin
            if (!need_push) begin
               state_in = FE_IDLE;
            end else if (!qstat.full) begin
               qwr.push = 1'b1;
               state_in = FE_IDLE;
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

endmodule

@@ design/ghfs_queue.sv @@
// ---------------------------------------------------------------------------
// ghfs_queue
// Short first-word-fall-through queue of work words between front and back.
// ---------------------------------------------------------------------------
module ghfs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  ghfs_pkg::queue_wr_type     qwr,
   input  logic                       pop,
   output ghfs_pkg::queue_status_type qstat
);
   import ghfs_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W:0]   count_ff;
   logic              do_push;
   logic              do_pop;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign qstat.head  = entry_ff[rd_ptr_ff];
   assign do_push     = qwr.push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= qwr.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + (QPTR_W+1)'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - (QPTR_W+1)'(1);
         end
      end
   end

endmodule

@@ design/ghfs_back.sv @@
// ---------------------------------------------------------------------------
// ghfs_back
// Shared divider and square root, histograms, peaks and bin record output.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ghfs_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ghfs_pkg::cfg_type          cfg,
   input  ghfs_pkg::queue_status_type qstat,
   output logic                       pop,
   ghfs_rsp_if.source                 rsp
);
   import ghfs_pkg::*;

   back_state_type state_ff, state_in;

   job_type           job_ff;
   logic [1:0]        sel_ff;
   logic              k_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [MAG_W-1:0]  num_ff, dvs_ff, rem_ff;
   logic [MAG_W-1:0]  quot_ff [4];
   logic [RAD_W-1:0]  sq_ff, rad_ff, root_ff, bit_ff;
   logic [BIN_W-1:0]  idx_ff;

   logic [CNT_W-1:0]    hist_small_ff [NUM_BINS];
   logic [CNT_W-1:0]    hist_large_ff [NUM_BINS];
   logic [PEAK_S_W-1:0] peak_small_ff;
   logic [PEAK_L_W-1:0] peak_large_ff;

   logic                rsp_valid_ff;
   logic [BIN_W-1:0]    rsp_bin_ff;
   logic [CNT_W-1:0]    rsp_cs_ff, rsp_cl_ff;
   logic [PEAK_S_W-1:0] rsp_ms_ff;
   logic [PEAK_L_W-1:0] rsp_ml_ff;
   logic                rsp_clear_ff;
   logic                rsp_last_ff;

   logic [MAG_W-1:0]  op_mag, op_div;
   logic [MAG_W:0]    trial;
   logic              fits;
   logic [MAG_W-1:0]  rem_in, num_in;
   logic [MAG_W-1:0]  qh, qv;
   logic [RAD_W:0]    root_try;
   logic              root_fits;
   logic [ROOT_W-1:0] grad;
   logic [BIN_W-1:0]  grad_bin;
   logic [BIN_W-1:0]  hist_addr;
   logic [CNT_W-1:0]  rd_small, rd_large;
   logic              rsp_done;

   always_comb begin
      unique case (sel_ff)
         2'd0: begin op_mag = job_ff.mag_h3; op_div = job_ff.div_h3; end
         2'd1: begin op_mag = job_ff.mag_v3; op_div = job_ff.div_v3; end
         2'd2: begin op_mag = job_ff.mag_h5; op_div = job_ff.div_h5; end
         default: begin op_mag = job_ff.mag_v5; op_div = job_ff.div_v5; end
      endcase
   end

   // Restoring division, one quotient bit per cycle.
   assign trial  = {rem_ff, num_ff[MAG_W-1]};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign rem_in = fits ? MAG_W'(trial - {1'b0, dvs_ff}) : trial[MAG_W-1:0];
   assign num_in = {num_ff[MAG_W-2:0], fits};

   assign qh = quot_ff[{k_ff, 1'b0}];
   assign qv = quot_ff[{k_ff, 1'b1}];

   assign root_try  = {1'b0, root_ff} + {1'b0, bit_ff};
   assign root_fits = {1'b0, rad_ff} >= root_try;

   assign grad      = root_ff[ROOT_W-1:0];
   assign grad_bin  = (|grad[ROOT_W-1:8]) ? BIN_W'(NUM_BINS - 1) : grad[7:4];
   assign hist_addr = (state_ff == BE_UPDATE) ? grad_bin : idx_ff;
   assign rd_small  = hist_small_ff[hist_addr];
   assign rd_large  = hist_large_ff[hist_addr];

   assign rsp_done = rsp_valid_ff && rsp.ready;

   always_ff @(posedge clock) begin
      unique case (state_ff)
         BE_IDLE: begin
            if (!qstat.empty) begin
               job_ff <= qstat.head;
            end
         end
         BE_DISPATCH: begin
            sel_ff <= 2'd0;
            idx_ff <= '0;
         end
         BE_DIV_LOAD: begin
            num_ff  <= op_mag;
            dvs_ff  <= (op_div == '0) ? MAG_W'(1) : op_div;
            rem_ff  <= '0;
            iter_ff <= '0;
         end
         BE_DIV: begin
            rem_ff  <= rem_in;
            num_ff  <= num_in;
            iter_ff <= iter_ff + ITER_W'(1);
            if (iter_ff == ITER_W'(MAG_W - 1)) begin
               quot_ff[sel_ff] <= num_in;
               sel_ff          <= sel_ff + 2'd1;
               k_ff            <= 1'b0;
            end
         end
         BE_SQ_H: begin
            sq_ff <= RAD_W'(qh * qh);
         end
         BE_SQ_V: begin
            rad_ff  <= sq_ff + RAD_W'(qv * qv);
            root_ff <= '0;
            bit_ff  <= ROOT_START;
         end
         BE_SQRT: begin
            if (root_fits) begin
               rad_ff  <= rad_ff - root_try[RAD_W-1:0];
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         BE_UPDATE: begin
            k_ff   <= ~k_ff;
            idx_ff <= '0;
         end
         BE_EMIT_WAIT: begin
            if (rsp_done) begin
               idx_ff <= idx_ff + BIN_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_small_ff <= '0;
         peak_large_ff <= '0;
         for (int b = 0; b < NUM_BINS; b++) begin
            hist_small_ff[b] <= '0;
            hist_large_ff[b] <= '0;
         end
      end else if (state_ff == BE_UPDATE) begin
         if (!k_ff) begin
            if (rd_small != COUNT_MAX) begin
               hist_small_ff[hist_addr] <= rd_small + CNT_W'(1);
            end
            if (grad[PEAK_S_W-1:0] > peak_small_ff) begin
               peak_small_ff <= grad[PEAK_S_W-1:0];
            end
         end else begin
            if (rd_large != COUNT_MAX) begin
               hist_large_ff[hist_addr] <= rd_large + CNT_W'(1);
            end
            if (grad > peak_large_ff) begin
               peak_large_ff <= grad;
            end
         end
      end else if (state_ff == BE_EMIT_LOAD) begin
         // Each bin is cleared as its record is loaded for the next frame.
         hist_small_ff[hist_addr] <= '0;
         hist_large_ff[hist_addr] <= '0;
      end else if (state_ff == BE_EMIT_WAIT && rsp_done && rsp_last_ff) begin
         peak_small_ff <= '0;
         peak_large_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BE_EMIT_LOAD) begin
         rsp_bin_ff   <= idx_ff;
         rsp_cs_ff    <= rd_small;
         rsp_cl_ff    <= rd_large;
         rsp_ms_ff    <= peak_small_ff;
         rsp_ml_ff    <= peak_large_ff;
         rsp_clear_ff <= (peak_small_ff >= cfg.thr_small) &&
                         (peak_large_ff >= cfg.thr_large);
         rsp_last_ff  <= (idx_ff == BIN_W'(NUM_BINS - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BE_EMIT_LOAD) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_done) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            if (!qstat.empty) begin
               pop      = 1'b1;
               state_in = BE_DISPATCH;
            end
         end
         BE_DISPATCH: begin
            state_in = job_ff.evaluate ? BE_DIV_LOAD : BE_EMIT_LOAD;
         end
         BE_DIV_LOAD: begin
            state_in = BE_DIV;
         end
         BE_DIV: begin
            if (iter_ff == ITER_W'(MAG_W - 1)) begin
               state_in = (sel_ff == 2'd3) ? BE_SQ_H : BE_DIV_LOAD;
            end
         end
         BE_SQ_H: begin
            state_in = BE_SQ_V;
         end
         BE_SQ_V: begin
            state_in = BE_SQRT;
         end
         BE_SQRT: begin
            if (bit_ff == RAD_W'(1)) begin
               state_in = BE_UPDATE;
            end
         end
         BE_UPDATE: begin
            if (!k_ff) begin
               state_in = BE_SQ_H;
            end else begin
               state_in = job_ff.eof ? BE_EMIT_LOAD : BE_IDLE;
            end
         end
         BE_EMIT_LOAD: begin
            state_in = BE_EMIT_WAIT;
         end
         BE_EMIT_WAIT: begin
            if (rsp_done) begin
               state_in = rsp_last_ff ? BE_IDLE : BE_EMIT_LOAD;
            end
         end
         default: begin
            state_in = BE_IDLE;
         end
      endcase
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.bin_index   = rsp_bin_ff;
   assign rsp.count_small = rsp_cs_ff;
   assign rsp.count_large = rsp_cl_ff;
   assign rsp.max_small   = rsp_ms_ff;
   assign rsp.max_large   = rsp_ml_ff;
   assign rsp.is_clear    = rsp_clear_ff;
   assign rsp.last        = rsp_last_ff;

   `GHFS_ASSERT(a_valid_in_emit, rsp_valid_ff |-> (state_ff == BE_EMIT_WAIT), "record word outside emit")
   `GHFS_ASSERT(a_peaks_cleared, (rsp_done && rsp_last_ff) |=> (peak_small_ff == '0 && peak_large_ff == '0), "peaks not cleared after frame")
   `GHFS_ASSERT_ALWAYS(a_pop_nonempty, pop |-> !qstat.empty, "pop from empty queue")

endmodule

@@ design/gradient_histogram_frame_stats.sv @@
// ---------------------------------------------------------------------------
// gradient_histogram_frame_stats
// Per-frame 3x3 and 5x5 gradient histograms and maxima over a region.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one pixel word per handshake in raster order; end_of_frame
//   marks the last pixel. rsp_bus returns 16 bin records after that pixel,
//   bin 0 first, with last set on bin 15. csr_bus writes a register by index;
//   writes are always taken and are meant for when the block is idle.
//   The front end takes one pixel at a time (read of the four line banks,
//   window shift, tap sums) and is ready for the next only when idle. Pixels
//   whose centre lies in the region queue a word for the back end, which runs
//   four divisions on one shared divider and two 14-step square roots for it.
//   The four-word queue lets the front end run ahead of that. After the
//   end-of-frame pixel, each record is loaded into the record register, and a
//   stalled receiver holds it there; the front keeps accepting until the queue
//   fills. Reset clears the window, counters, histograms, maxima, queue and
//   state registers; line memories and data registers are not cleared.
// ---------------------------------------------------------------------------
module gradient_histogram_frame_stats (
   input  logic        clock,
   input  logic        reset,
   ghfs_req_if.sink    req_bus,
   ghfs_rsp_if.source  rsp_bus,
   ghfs_csr_if.sink    csr_bus
);
   import ghfs_pkg::*;

   cfg_type          cfg_ff;
   queue_wr_type     qwr;
   queue_status_type qstat;
   logic             pop;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= IMG_W_W'(648);
         cfg_ff.roi_col_start <= ROI_W'(216);
         cfg_ff.roi_col_end   <= ROI_W'(432);
         cfg_ff.roi_row_start <= ROI_W'(162);
         cfg_ff.roi_row_end   <= ROI_W'(324);
         cfg_ff.thr_small     <= THR_S_W'(1250);
         cfg_ff.thr_large     <= THR_L_W'(200);
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.reg_index))
            REG_IMAGE_WIDTH:   cfg_ff.image_width   <= csr_bus.wdata[IMG_W_W-1:0];
            REG_ROI_COL_START: cfg_ff.roi_col_start <= csr_bus.wdata[ROI_W-1:0];
            REG_ROI_COL_END:   cfg_ff.roi_col_end   <= csr_bus.wdata[ROI_W-1:0];
            REG_ROI_ROW_START: cfg_ff.roi_row_start <= csr_bus.wdata[ROI_W-1:0];
            REG_ROI_ROW_END:   cfg_ff.roi_row_end   <= csr_bus.wdata[ROI_W-1:0];
            REG_THR_SMALL:     cfg_ff.thr_small     <= csr_bus.wdata[THR_S_W-1:0];
            REG_THR_LARGE:     cfg_ff.thr_large     <= csr_bus.wdata[THR_L_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ghfs_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .cfg   (cfg_ff),
      .qstat (qstat),
      .qwr   (qwr)
   );

   ghfs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qwr   (qwr),
      .pop   (pop),
      .qstat (qstat)
   );

   ghfs_back u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .qstat (qstat),
      .pop   (pop),
      .rsp   (rsp_bus)
   );

endmodule
